// ===== design/imm_pkg.sv =====
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types, constants and helpers for the integer matrix multiplier.
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int MAX_DIM   = 8;
  localparam int ELEM_BITS = 16;
  localparam int SUM_BITS  = 35;
  localparam int IN_BITS   = 16;
  localparam int IDX_BITS  = 3;
  localparam int DIM_BITS  = 4;
  localparam int CMD_BITS  = 2;
  localparam int CFG_BITS  = 2;
  localparam int PROD_BITS = 2 * ELEM_BITS;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_WRITE_A = 2'd0,
    CMD_WRITE_B = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_t;

  typedef enum logic [CFG_BITS-1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Tag that travels with each multiply-accumulate beat
  typedef struct packed {
    logic                first;
    logic                dot_end;
    logic                last;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
  } mac_tag_t;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
    logic [DIM_BITS-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_BITS'(1);
    end else if (v > DIM_BITS'(MAX_DIM)) begin
      r = DIM_BITS'(MAX_DIM);
    end
    return r;
  endfunction

  function automatic logic [ADDR_BITS-1:0] elem_addr(input logic [IDX_BITS-1:0] r,
                                                     input logic [IDX_BITS-1:0] c);
    return ADDR_BITS'(int'(r) * MAX_DIM + int'(c));
  endfunction

endpackage

// ===== design/imm_ram.sv =====
// ----------------------------------------------------------------------------
// imm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/imm_seq.sv =====
// ----------------------------------------------------------------------------
// imm_seq
// Sequencer: walks row, column and inner index and issues one read pair
// per cycle to the element stores.
// ----------------------------------------------------------------------------
module imm_seq import imm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [DIM_BITS-1:0]  ra,
  input  logic [DIM_BITS-1:0]  kd,
  input  logic [DIM_BITS-1:0]  cb,
  output logic                 running,
  output logic                 issue_valid,
  output mac_tag_t             issue_tag,
  output logic [ADDR_BITS-1:0] addr_a,
  output logic [ADDR_BITS-1:0] addr_b
);

  state_t              state_r, state_nxt;
  logic [IDX_BITS-1:0] i_r, i_nxt;
  logic [IDX_BITS-1:0] j_r, j_nxt;
  logic [IDX_BITS-1:0] k_r, k_nxt;
  logic                i_end, j_end, k_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  assign i_end = ({1'b0, i_r} == ra - DIM_BITS'(1));
  assign j_end = ({1'b0, j_r} == cb - DIM_BITS'(1));
  assign k_end = ({1'b0, k_r} == kd - DIM_BITS'(1));

  assign addr_a            = elem_addr(i_r, k_r);
  assign addr_b            = elem_addr(k_r, j_r);
  assign issue_tag.first   = (k_r == '0);
  assign issue_tag.dot_end = k_end;
  assign issue_tag.last    = k_end && j_end && i_end;
  assign issue_tag.row     = i_r;
  assign issue_tag.col     = j_r;
  assign running           = (state_r == ST_RUN);

  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    issue_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (go) begin
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        issue_valid = 1'b1;
        if (k_end) begin
          k_nxt = '0;
          if (j_end) begin
            j_nxt = '0;
            if (i_end) begin
              state_nxt = ST_IDLE;
            end else begin
              i_nxt = i_r + IDX_BITS'(1);
            end
          end else begin
            j_nxt = j_r + IDX_BITS'(1);
          end
        end else begin
          k_nxt = k_r + IDX_BITS'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/imm_mac.sv =====
// ----------------------------------------------------------------------------
// imm_mac
// Shared multiply-accumulate unit: registered product, running sum and
// result strobe.
// ----------------------------------------------------------------------------
module imm_mac import imm_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        issue_valid,
  input  mac_tag_t                    issue_tag,
  input  logic signed [ELEM_BITS-1:0] a_data,
  input  logic signed [ELEM_BITS-1:0] b_data,
  output logic                        pipe_busy,
  output logic                        out_valid,
  output logic [IDX_BITS-1:0]         out_row,
  output logic [IDX_BITS-1:0]         out_col,
  output logic signed [SUM_BITS-1:0]  out_product_sum,
  output logic                        out_last
);

  logic                        s1_v_r;
  mac_tag_t                    s1_tag_r;
  logic                        s2_v_r;
  mac_tag_t                    s2_tag_r;
  logic signed [PROD_BITS-1:0] prod_r;
  logic signed [SUM_BITS-1:0]  acc_r;
  logic signed [SUM_BITS-1:0]  acc_nxt;
  logic                        out_valid_r;
  logic                        out_last_r;
  logic [IDX_BITS-1:0]         out_row_r;
  logic [IDX_BITS-1:0]         out_col_r;
  logic signed [SUM_BITS-1:0]  out_sum_r;

  assign acc_nxt = (s2_tag_r.first ? SUM_BITS'(0) : acc_r) + SUM_BITS'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      s1_v_r      <= issue_valid;
      s2_v_r      <= s1_v_r;
      out_valid_r <= s2_v_r && s2_tag_r.dot_end;
      out_last_r  <= s2_v_r && s2_tag_r.dot_end && s2_tag_r.last;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag_r <= issue_tag;
    s2_tag_r <= s1_tag_r;
    prod_r   <= a_data * b_data;
    if (s2_v_r) begin
      acc_r <= acc_nxt;
    end
    if (s2_v_r && s2_tag_r.dot_end) begin
      out_row_r <= s2_tag_r.row;
      out_col_r <= s2_tag_r.col;
      out_sum_r <= acc_nxt;
    end
  end

  assign pipe_busy       = s1_v_r || s2_v_r;
  assign out_valid       = out_valid_r;
  assign out_last        = out_last_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_product_sum = out_sum_r;

endmodule

// ===== design/integer_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Signed integer matrix multiply C = A * B over indexed element stores.
// ----------------------------------------------------------------------------
// An element write leaves busy low, so writes may arrive every cycle. A
// compute command holds busy high while the sequencer runs and the
// multiplier pipeline drains: one shared multiplier and one read port per
// element store give one multiply-accumulate per cycle. Results come out
// in row-major order, each on out_valid for one cycle only; the receiver
// must take every beat as it comes. Configuration writes are always taken
// (cfg_ready high) and the user must keep them to idle periods; the block
// itself does not enforce this.
module integer_matrix_multiply import imm_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [CMD_BITS-1:0]         in_command,
  input  logic [IDX_BITS-1:0]         in_row,
  input  logic [IDX_BITS-1:0]         in_col,
  input  logic signed [IN_BITS-1:0]   in_element,
  output logic                        out_valid,
  output logic [IDX_BITS-1:0]         out_row,
  output logic [IDX_BITS-1:0]         out_col,
  output logic signed [SUM_BITS-1:0]  out_product_sum,
  output logic                        out_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_BITS-1:0]         cfg_index,
  input  logic [DIM_BITS-1:0]         cfg_data
);

  logic [DIM_BITS-1:0]         rows_a_r;
  logic [DIM_BITS-1:0]         inner_dim_r;
  logic [DIM_BITS-1:0]         cols_b_r;
  logic [DIM_BITS-1:0]         ra, kd, cb;
  logic                        accept;
  logic                        we_a, we_b, go;
  logic [ADDR_BITS-1:0]        waddr;
  logic signed [ELEM_BITS-1:0] wdata;
  logic                        running;
  logic                        pipe_busy;
  logic                        issue_valid;
  mac_tag_t                    issue_tag;
  logic [ADDR_BITS-1:0]        addr_a, addr_b;
  logic signed [ELEM_BITS-1:0] a_data, b_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_BITS'(MAX_DIM);
      inner_dim_r <= DIM_BITS'(MAX_DIM);
      cols_b_r    <= DIM_BITS'(MAX_DIM);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROWS_A:    rows_a_r    <= cfg_data;
        REG_INNER_DIM: inner_dim_r <= cfg_data;
        REG_COLS_B:    cols_b_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign ra = clamp_dim(rows_a_r);
  assign kd = clamp_dim(inner_dim_r);
  assign cb = clamp_dim(cols_b_r);

  assign busy   = running || pipe_busy;
  assign accept = start && !busy;
  assign waddr  = elem_addr(in_row, in_col);
  assign wdata  = ELEM_BITS'(in_element);

  always_comb begin
    we_a = 1'b0;
    we_b = 1'b0;
    go   = 1'b0;
    case (cmd_t'(in_command))
      CMD_WRITE_A: we_a = accept && ({1'b0, in_row} < ra) && ({1'b0, in_col} < kd);
      CMD_WRITE_B: we_b = accept && ({1'b0, in_row} < kd) && ({1'b0, in_col} < cb);
      CMD_COMPUTE: go   = accept;
      default: begin
      end
    endcase
  end

  imm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr_a),
    .rdata (a_data)
  );

  imm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr_b),
    .rdata (b_data)
  );

  imm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (go),
    .ra          (ra),
    .kd          (kd),
    .cb          (cb),
    .running     (running),
    .issue_valid (issue_valid),
    .issue_tag   (issue_tag),
    .addr_a      (addr_a),
    .addr_b      (addr_b)
  );

  imm_mac u_mac (
    .clk             (clk),
    .rst_n           (rst_n),
    .issue_valid     (issue_valid),
    .issue_tag       (issue_tag),
    .a_data          (a_data),
    .b_data          (b_data),
    .pipe_busy       (pipe_busy),
    .out_valid       (out_valid),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_product_sum (out_product_sum),
    .out_last        (out_last)
  );

endmodule

// ===== design/imm_checker.sv =====
// ----------------------------------------------------------------------------
// imm_checker
// Port-level checks on the command, busy and result strobe behavior.
// ----------------------------------------------------------------------------
module imm_checker import imm_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [CMD_BITS-1:0]        in_command,
  input logic                       out_valid,
  input logic                       out_last
);

  a_compute_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command == CMD_COMPUTE |=> busy)
    else $error("compute command did not raise busy");

  a_result_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a running compute");

  a_more_results_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("busy dropped before the final result beat");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result beat after the final one");

  a_last_is_strobed: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("last marker outside a result beat");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_command (in_command),
  .out_valid  (out_valid),
  .out_last   (out_last)
);
